// ===== hw/rtl/izm_pkg.sv =====
// Shared types and constants for the inter-zone mailbox unit.
// Holds the request and response payload structs and the mailbox geometry.
// No dependencies.
`timescale 1ns / 1ps

package izm_pkg;

	localparam int ZONE_COUNT    = 8;
	localparam int MESSAGE_WORDS = 7;
	localparam int WORD_FIELDS   = 7;
	localparam int WORD_W        = 32;

	localparam int ZONE_W    = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
	localparam int BOX_COUNT = ZONE_COUNT * ZONE_COUNT;
	localparam int BOX_W     = (BOX_COUNT > 1) ? $clog2(BOX_COUNT) : 1;

	localparam logic ACT_SEND = 1'b0;
	localparam logic ACT_RECV = 1'b1;

	typedef logic [ZONE_W-1:0] izm_zone_t;
	typedef logic [BOX_W-1:0] izm_box_t;
	typedef logic [MESSAGE_WORDS-1:0][WORD_W-1:0] izm_msg_t;
	typedef logic [WORD_FIELDS-1:0][WORD_W-1:0] izm_words_t;

	typedef struct packed {
		logic        action;
		logic [3:0]  caller_zone;
		logic [31:0] peer_zone;
		logic [31:0] word_in_0;
		logic [31:0] word_in_1;
		logic [31:0] word_in_2;
		logic [31:0] word_in_3;
		logic [31:0] word_in_4;
		logic [31:0] word_in_5;
		logic [31:0] word_in_6;
	} izm_req_t;

	typedef struct packed {
		logic        success;
		logic [31:0] word_out_0;
		logic [31:0] word_out_1;
		logic [31:0] word_out_2;
		logic [31:0] word_out_3;
		logic [31:0] word_out_4;
		logic [31:0] word_out_5;
		logic [31:0] word_out_6;
	} izm_rsp_t;

endpackage

// ===== hw/rtl/inter_zone_mailbox_unit.sv =====
// Inter-zone mailbox unit: one-deep mailbox per ordered pair of zones.
// Depends on izm_pkg for payload types and mailbox geometry.
//
// Usage:
//   A request enters on req when req_valid is high and req_stall is low.
//   A send (action 0) stores its words in the peer's mailbox for the caller
//   if that mailbox is empty; a receive (action 1) takes the words from the
//   caller's mailbox for the named peer if it is full. Invalid zone numbers,
//   sends to a full mailbox and receives from an empty one fail and echo the
//   request words with success low.
//   Every request gives one response on rsp, taken when rsp_valid is high and
//   rsp_stall is low.
//   Requests pass a first stage, then the response register; throughput is
//   one request per cycle while rsp_stall is low. The message memory is
//   read once as a request enters the first stage and written once as it
//   leaves, bypassing that write to a same-mailbox read in the same cycle.
//   When rsp_stall is held the response register and the first stage hold;
//   req_stall rises once both are occupied.
//   Reset empties every mailbox at once (full flags only); message storage
//   is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module inter_zone_mailbox_unit
	import izm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  izm_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output izm_rsp_t rsp
);

	logic       accept;
	logic       s1_adv;
	logic       caller_ok;
	logic       peer_ok;
	izm_zone_t  c_idx;
	izm_zone_t  p_idx;
	izm_zone_t  row_idx;
	izm_zone_t  col_idx;
	izm_box_t   box_in;
	logic       wr_en;

	logic       s1_valid;
	izm_req_t   req_s1;
	izm_box_t   box_s1;
	logic       zone_ok_s1;
	izm_msg_t   rd_s1;
	logic       fwd_s1;
	izm_msg_t   fwd_data_s1;

	izm_words_t words_s1;
	izm_words_t out_words;
	izm_msg_t   send_msg;
	izm_msg_t   stored_msg;
	logic       box_full;
	logic       ok_s1;

	logic       rsp_valid_q;
	izm_rsp_t   rsp_q;
	logic [BOX_COUNT-1:0] full_q;
	izm_msg_t   mbox_mem_q [BOX_COUNT];

	assign s1_adv    = s1_valid && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_valid && !s1_adv;
	assign accept    = req_valid && !req_stall;

	assign caller_ok = (req.caller_zone != 4'd0) &&
		(32'(req.caller_zone) <= 32'(ZONE_COUNT));
	assign peer_ok   = (req.peer_zone != 32'd0) && (req.peer_zone <= 32'(ZONE_COUNT));
	assign c_idx     = ZONE_W'(32'(req.caller_zone) - 32'd1);
	assign p_idx     = ZONE_W'(req.peer_zone - 32'd1);
	assign row_idx   = (req.action == ACT_RECV) ? c_idx : p_idx;
	assign col_idx   = (req.action == ACT_RECV) ? p_idx : c_idx;
	assign box_in    = (caller_ok && peer_ok) ?
		BOX_W'(BOX_W'(row_idx) * BOX_W'(ZONE_COUNT) + BOX_W'(col_idx)) : '0;

	assign words_s1 = {req_s1.word_in_6, req_s1.word_in_5, req_s1.word_in_4,
		req_s1.word_in_3, req_s1.word_in_2, req_s1.word_in_1, req_s1.word_in_0};

	always_comb begin
		for (int j = 0; j < MESSAGE_WORDS; j++) begin
			send_msg[j] = words_s1[j];
		end
	end

	assign stored_msg = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign box_full   = full_q[box_s1];
	assign ok_s1      = zone_ok_s1 &&
		((req_s1.action == ACT_SEND) ? !box_full : box_full);
	assign wr_en      = s1_adv && ok_s1 && (req_s1.action == ACT_SEND);

	always_comb begin
		out_words = words_s1;
		if (ok_s1 && req_s1.action == ACT_RECV) begin
			for (int j = 0; j < MESSAGE_WORDS; j++) begin
				out_words[j] = stored_msg[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			rsp_valid_q <= 1'b0;
			full_q      <= '0;
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
			if (s1_adv) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (s1_adv && ok_s1) begin
				full_q[box_s1] <= (req_s1.action == ACT_SEND);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= req;
			box_s1      <= box_in;
			zone_ok_s1  <= caller_ok && peer_ok;
			fwd_s1      <= wr_en && (box_s1 == box_in);
			fwd_data_s1 <= send_msg;
		end
		if (s1_adv) begin
			rsp_q.success    <= ok_s1;
			rsp_q.word_out_0 <= out_words[0];
			rsp_q.word_out_1 <= out_words[1];
			rsp_q.word_out_2 <= out_words[2];
			rsp_q.word_out_3 <= out_words[3];
			rsp_q.word_out_4 <= out_words[4];
			rsp_q.word_out_5 <= out_words[5];
			rsp_q.word_out_6 <= out_words[6];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mbox_mem_q[box_in];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mbox_mem_q[box_s1] <= send_msg;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_send_sets_full: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && ok_s1 && req_s1.action == ACT_SEND) |=> full_q[$past(box_s1)])
		else $error("successful send did not mark mailbox full");

	a_recv_clears_full: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && ok_s1 && req_s1.action == ACT_RECV) |=> !full_q[$past(box_s1)])
		else $error("successful receive did not empty mailbox");

	a_fail_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_adv && ok_s1) |=> (full_q == $past(full_q)))
		else $error("mailbox flags changed without a successful request");

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (s1_valid && rsp_valid_q && rsp_stall))
		else $error("request stalled while pipeline has room");

	a_commit_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> rsp_valid)
		else $error("committed request produced no response");

endmodule
